[src/fmlm_pkg.sv]
package fmlm_pkg;

    localparam int NUM_MUTEX_DEF = 32;
    localparam int NUM_TASKS_DEF = 64;
    localparam int QUEUE_DEPTH   = 2;

    localparam int FUNC_W   = 2;
    localparam int MID_W    = 6;
    localparam int TASK_W   = 6;
    localparam int STATUS_W = 3;
    localparam int NEW_W    = 5;

    typedef enum logic [FUNC_W-1:0] {
        OP_CREATE = 2'd0,
        OP_LOCK   = 2'd1,
        OP_UNLOCK = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOMEM    = 3'd1,
        ST_INVALID  = 3'd2,
        ST_DEADLOCK = 3'd3,
        ST_NOTOWNER = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_LINK
    } t_back_state;

    typedef struct packed {
        t_op               op;
        logic              mid_ok;
        logic [MID_W-1:0]  mid;
        logic [TASK_W-1:0] task_id;
    } t_req;

    typedef struct packed {
        logic [TASK_W-1:0] woken_task;
        logic              woken_valid;
        logic              blocked;
        logic [NEW_W-1:0]  new_mutex;
        t_status           status;
    } t_resp;

    typedef struct packed {
        logic [TASK_W-1:0] owner;
        logic [TASK_W-1:0] head;
        logic [TASK_W-1:0] tail;
    } t_mtx_entry;

endpackage

[src/fmlm_ram.sv]
module fmlm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/fmlm_front.sv]
module fmlm_front #(
    parameter int NUM_MUTEX = fmlm_pkg::NUM_MUTEX_DEF,
    parameter int NUM_TASKS = fmlm_pkg::NUM_TASKS_DEF
) (
    input  logic                          i_valid,
    input  logic [fmlm_pkg::FUNC_W-1:0]   i_func,
    input  logic [fmlm_pkg::MID_W-1:0]    i_mutex_id,
    input  logic [fmlm_pkg::TASK_W-1:0]   i_task_id,
    input  logic                          i_full,
    output logic                          o_ready,
    output logic                          o_push,
    output fmlm_pkg::t_req                o_req
);

    localparam int RW = 2 * fmlm_pkg::TASK_W + 1;

    function automatic logic [fmlm_pkg::TASK_W-1:0] f_task_mod(
        input logic [fmlm_pkg::TASK_W-1:0] v
    );
        logic [RW-1:0] rem;
        logic [RW-1:0] d;
        rem = RW'(v);
        for (int k = fmlm_pkg::TASK_W - 1; k >= 0; k--) begin
            d = RW'(NUM_TASKS) << k;
            if (rem >= d) begin
                rem = rem - d;
            end
        end
        return rem[fmlm_pkg::TASK_W-1:0];
    endfunction

    logic w_mid_ok;

    assign w_mid_ok = ({1'b0, i_mutex_id} < (fmlm_pkg::MID_W + 1)'(NUM_MUTEX));

    always_comb begin
        o_req         = '0;
        o_req.op      = fmlm_pkg::t_op'(i_func);
        o_req.mid_ok  = w_mid_ok;
        o_req.mid     = w_mid_ok ? i_mutex_id : '0;
        o_req.task_id = f_task_mod(i_task_id);
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

[src/fmlm_queue.sv]
module fmlm_queue #(
    parameter int DEPTH = fmlm_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fmlm_pkg::t_req i_data,
    input  logic           i_pop,
    output fmlm_pkg::t_req o_data,
    output logic           o_full,
    output logic           o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fmlm_pkg::t_req r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule

[src/fmlm_back.sv]
module fmlm_back #(
    parameter int NUM_MUTEX = fmlm_pkg::NUM_MUTEX_DEF,
    parameter int NUM_TASKS = fmlm_pkg::NUM_TASKS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  fmlm_pkg::t_req  i_q_req,
    output logic            o_q_pop,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output fmlm_pkg::t_resp o_out_data
);

    localparam int MW = (NUM_MUTEX > 1) ? $clog2(NUM_MUTEX) : 1;
    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int EW = $bits(fmlm_pkg::t_mtx_entry);

    fmlm_pkg::t_back_state r_state, n_state;
    fmlm_pkg::t_req        r_req, n_req;
    logic [NUM_MUTEX-1:0]  r_free, n_free;
    logic [NUM_MUTEX-1:0]  r_locked, n_locked;
    logic [NUM_MUTEX-1:0]  r_qne, n_qne;
    logic                  r_found, n_found;
    logic [MW-1:0]         r_free_idx, n_free_idx;
    logic                  r_out_valid, n_out_valid;
    fmlm_pkg::t_resp       r_out, n_out;

    logic                       w_found;
    logic [MW-1:0]              w_idx;
    logic [MW-1:0]              w_mi;
    logic                       w_out_free;
    fmlm_pkg::t_resp            w_resp;
    fmlm_pkg::t_mtx_entry       w_ent;
    fmlm_pkg::t_mtx_entry       w_tbl_wdata;
    logic [EW-1:0]              w_tbl_rdata;
    logic                       w_tbl_we;
    logic                       w_tbl_re;
    logic                       w_nw_we;
    logic                       w_nw_re;
    logic [TW-1:0]              w_nw_waddr;
    logic [fmlm_pkg::TASK_W-1:0] w_nw_rdata;

    fmlm_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_MUTEX)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (w_tbl_we),
        .i_waddr (w_mi),
        .i_wdata (w_tbl_wdata),
        .i_re    (w_tbl_re),
        .i_raddr (i_q_req.mid[MW-1:0]),
        .o_rdata (w_tbl_rdata)
    );

    fmlm_ram #(
        .WIDTH (fmlm_pkg::TASK_W),
        .DEPTH (NUM_TASKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_nw_we),
        .i_waddr (w_nw_waddr),
        .i_wdata (r_req.task_id),
        .i_re    (w_nw_re),
        .i_raddr (w_ent.head[TW-1:0]),
        .o_rdata (w_nw_rdata)
    );

    assign w_ent      = fmlm_pkg::t_mtx_entry'(w_tbl_rdata);
    assign w_mi       = r_req.mid[MW-1:0];
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        w_found = 1'b0;
        w_idx   = '0;
        for (int i = NUM_MUTEX - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                w_found = 1'b1;
                w_idx   = MW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_free      = r_free;
        n_locked    = r_locked;
        n_qne       = r_qne;
        n_found     = r_found;
        n_free_idx  = r_free_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        w_tbl_re    = 1'b0;
        w_tbl_we    = 1'b0;
        w_tbl_wdata = w_ent;
        w_nw_we     = 1'b0;
        w_nw_re     = 1'b0;
        w_nw_waddr  = w_ent.tail[TW-1:0];
        w_resp      = '0;
        w_resp.status = fmlm_pkg::ST_OK;

        unique case (r_state)
            fmlm_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop    = 1'b1;
                    w_tbl_re   = 1'b1;
                    n_req      = i_q_req;
                    n_found    = w_found;
                    n_free_idx = w_idx;
                    n_state    = fmlm_pkg::BK_EXEC;
                end
            end
            fmlm_pkg::BK_EXEC: begin
                if (w_out_free) begin
                    n_state = fmlm_pkg::BK_IDLE;
                    unique case (r_req.op)
                        fmlm_pkg::OP_CREATE: begin
                            if (r_found) begin
                                n_free[r_free_idx] = 1'b0;
                                w_resp.new_mutex   = fmlm_pkg::NEW_W'(r_free_idx);
                            end else begin
                                w_resp.status = fmlm_pkg::ST_NOMEM;
                            end
                        end
                        fmlm_pkg::OP_LOCK: begin
                            if (!r_req.mid_ok || r_free[w_mi]) begin
                                w_resp.status = fmlm_pkg::ST_INVALID;
                            end else if (r_locked[w_mi] && w_ent.owner == r_req.task_id) begin
                                w_resp.status = fmlm_pkg::ST_DEADLOCK;
                            end else if (!r_locked[w_mi]) begin
                                n_locked[w_mi]    = 1'b1;
                                w_tbl_wdata.owner = r_req.task_id;
                                w_tbl_we          = 1'b1;
                            end else begin
                                if (r_qne[w_mi]) begin
                                    w_nw_we = 1'b1;
                                end else begin
                                    w_tbl_wdata.head = r_req.task_id;
                                    n_qne[w_mi]      = 1'b1;
                                end
                                w_tbl_wdata.tail = r_req.task_id;
                                w_tbl_we         = 1'b1;
                                w_resp.blocked   = 1'b1;
                            end
                        end
                        fmlm_pkg::OP_UNLOCK: begin
                            if (!r_req.mid_ok || r_free[w_mi]) begin
                                w_resp.status = fmlm_pkg::ST_INVALID;
                            end else if (!r_locked[w_mi] || w_ent.owner != r_req.task_id) begin
                                w_resp.status = fmlm_pkg::ST_NOTOWNER;
                            end else if (r_qne[w_mi]) begin
                                if (w_ent.head == w_ent.tail) begin
                                    n_qne[w_mi]        = 1'b0;
                                    w_tbl_wdata.owner  = w_ent.head;
                                    w_tbl_we           = 1'b1;
                                    w_resp.woken_valid = 1'b1;
                                    w_resp.woken_task  = w_ent.head;
                                end else begin
                                    w_nw_re = 1'b1;
                                    n_state = fmlm_pkg::BK_LINK;
                                end
                            end else begin
                                n_locked[w_mi] = 1'b0;
                            end
                        end
                        fmlm_pkg::OP_NONE: begin
                        end
                    endcase
                    if (n_state == fmlm_pkg::BK_IDLE) begin
                        n_out_valid = 1'b1;
                        n_out       = w_resp;
                    end
                end
            end
            fmlm_pkg::BK_LINK: begin
                if (w_out_free) begin
                    w_tbl_we           = 1'b1;
                    w_tbl_wdata.owner  = w_ent.head;
                    w_tbl_wdata.head   = w_nw_rdata;
                    w_resp.woken_valid = 1'b1;
                    w_resp.woken_task  = w_ent.head;
                    n_out_valid        = 1'b1;
                    n_out              = w_resp;
                    n_state            = fmlm_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = fmlm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fmlm_pkg::BK_IDLE;
            r_free      <= '1;
            r_locked    <= '0;
            r_qne       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_locked    <= n_locked;
            r_qne       <= n_qne;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_found    <= n_found;
        r_free_idx <= n_free_idx;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[src/fifo_mutex_lock_manager.sv]
// Mutex manager with first-in first-out waiter queues.
// Input channel s_*: one request item per handshake; s_tuser carries the
// request kind (create, lock, unlock, none), s_tdata the mutex id and task id.
// Output channel m_*: exactly one result item per request, in request order.
// A front stage classifies requests into a two-entry queue; the back end
// pops one request, reads the per-mutex table RAM, then updates the state
// and loads the output register.
// From accept, a request goes through the queue, BK_EXEC and the output
// register to m_tvalid; an unlock that passes ownership to a waiter with
// more waiters behind it adds BK_LINK (second dependent read of the
// waiter link RAM). The back end finishes one item before it pops the
// next, set by the table RAM read-modify-write.
// Reset: every mutex free and unlocked, all queues empty; no clearing pass.
// Receiver stall: the result holds in the output register, the back end
// waits, and the queue keeps taking requests until it is full.
module fifo_mutex_lock_manager #(
    parameter int NUM_MUTEX = fmlm_pkg::NUM_MUTEX_DEF,
    parameter int NUM_TASKS = fmlm_pkg::NUM_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // mutex_id[5:0], task_id[11:6], zero[15:12]
    input  logic [1:0]  s_tuser,  // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // status[2:0], new_mutex[7:3], blocked[8],
                                  // woken_valid[9], woken_task[15:10]
);

    fmlm_pkg::t_req  w_f_req;
    fmlm_pkg::t_req  w_q_req;
    fmlm_pkg::t_resp w_out;
    logic            w_push;
    logic            w_q_pop;
    logic            w_q_full;
    logic            w_q_empty;

    fmlm_front #(
        .NUM_MUTEX (NUM_MUTEX),
        .NUM_TASKS (NUM_TASKS)
    ) u_front (
        .i_valid    (s_tvalid),
        .i_func     (s_tuser),
        .i_mutex_id (s_tdata[5:0]),
        .i_task_id  (s_tdata[11:6]),
        .i_full     (w_q_full),
        .o_ready    (s_tready),
        .o_push     (w_push),
        .o_req      (w_f_req)
    );

    fmlm_queue #(
        .DEPTH (fmlm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_f_req),
        .i_pop   (w_q_pop),
        .o_data  (w_q_req),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    fmlm_back #(
        .NUM_MUTEX (NUM_MUTEX),
        .NUM_TASKS (NUM_TASKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_req     (w_q_req),
        .o_q_pop     (w_q_pop),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_out_data  (w_out)
    );

    assign m_tdata = w_out;

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("queue popped while empty");

    a_pop_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |=> !w_q_pop)
        else $error("back end popped in two successive cycles");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !w_q_empty)
        else $error("accepted item missing from queue");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import fmlm_pkg::*;

    localparam int NM        = NUM_MUTEX_DEF;
    localparam int NT        = NUM_TASKS_DEF;
    localparam int RAND_REQS = 1600;
    localparam int LIMIT     = 400000;
    localparam int SHOW_MAX  = 10;
    localparam int HOLD_LEN  = 300;

    typedef struct {
        t_op               op;
        logic [MID_W-1:0]  mid;
        logic [TASK_W-1:0] tsk;
        int                reps;
        bit                fixed;
        t_resp             want;
    } t_row;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;

    bit                mtx_alloc [NM];
    bit                mtx_held  [NM];
    logic [TASK_W-1:0] mtx_owner [NM];
    bit                wq_busy   [NM];
    logic [TASK_W-1:0] wq_head   [NM];
    logic [TASK_W-1:0] wq_tail   [NM];
    logic [TASK_W-1:0] wait_link [NT];
    bit                link_set  [NT];
    bit                tsk_waiting [NT];

    t_resp resp_q[$];
    t_row  rows[$];

    int n_err     = 0;
    int n_reqs    = 0;
    int n_results = 0;
    int n_blocked = 0;
    int n_woken   = 0;
    int n_status[5];
    int cycles    = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit hold_go   = 1'b0;
    bit calm      = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    fifo_mutex_lock_manager i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),  // mutex_id[5:0], task_id[11:6], zero[15:12]
        .s_tuser  (s_tuser),  // func[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)   // status[2:0], new_mutex[7:3], blocked[8],
                              // woken_valid[9], woken_task[15:10]
    );

    function automatic t_resp mutex_step(t_op op, logic [MID_W-1:0] mid,
                                         logic [TASK_W-1:0] tsk_in);
        t_resp             r;
        logic [TASK_W-1:0] tsk;
        logic [TASK_W-1:0] hd;
        bit                found;
        r     = '0;
        tsk   = TASK_W'(tsk_in % NT);
        found = 1'b0;
        case (op)
            OP_CREATE: begin
                r.status = ST_NOMEM;
                for (int i = 0; i < NM; i++) begin
                    if (!found && !mtx_alloc[i]) begin
                        found        = 1'b1;
                        mtx_alloc[i] = 1'b1;
                        r.status     = ST_OK;
                        r.new_mutex  = NEW_W'(i);
                    end
                end
            end
            OP_LOCK, OP_UNLOCK: begin
                if (mid >= NM || !mtx_alloc[mid]) begin
                    r.status = ST_INVALID;
                end else if (op == OP_LOCK) begin
                    if (mtx_held[mid] && mtx_owner[mid] == tsk) begin
                        r.status = ST_DEADLOCK;
                    end else if (!mtx_held[mid]) begin
                        mtx_held[mid]  = 1'b1;
                        mtx_owner[mid] = tsk;
                    end else begin
                        if (wq_busy[mid]) begin
                            wait_link[wq_tail[mid]] = tsk;
                            link_set[wq_tail[mid]]  = 1'b1;
                        end else begin
                            wq_head[mid] = tsk;
                            wq_busy[mid] = 1'b1;
                        end
                        wq_tail[mid]     = tsk;
                        tsk_waiting[tsk] = 1'b1;
                        r.blocked        = 1'b1;
                    end
                end else begin
                    if (!mtx_held[mid] || mtx_owner[mid] != tsk) begin
                        r.status = ST_NOTOWNER;
                    end else if (wq_busy[mid]) begin
                        hd              = wq_head[mid];
                        mtx_owner[mid]  = hd;
                        tsk_waiting[hd] = 1'b0;
                        r.woken_valid   = 1'b1;
                        r.woken_task    = hd;
                        if (hd == wq_tail[mid]) begin
                            wq_busy[mid] = 1'b0;
                        end else begin
                            wq_head[mid] = wait_link[hd];
                        end
                    end else begin
                        mtx_held[mid] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // a hand-over in a scrambled queue must not follow a link that was never set
    function automatic bit hits_blank_link(t_op op, logic [MID_W-1:0] mid,
                                           logic [TASK_W-1:0] tsk);
        return op == OP_UNLOCK && mid < NM && mtx_alloc[mid] && mtx_held[mid]
            && mtx_owner[mid] == tsk && wq_busy[mid]
            && wq_head[mid] != wq_tail[mid] && !link_set[wq_head[mid]];
    endfunction

    function automatic logic [TASK_W-1:0] pick_task();
        logic [TASK_W-1:0] t;
        t = TASK_W'($urandom_range(0, NT - 1));
        for (int i = 0; i < 4; i++) begin
            if (tsk_waiting[t]) t = TASK_W'($urandom_range(0, NT - 1));
        end
        return t;
    endfunction

    task automatic pick_req(output t_op op, output logic [MID_W-1:0] mid,
                            output logic [TASK_W-1:0] tsk);
        int r;
        do begin
            r   = $urandom_range(0, 99);
            mid = ($urandom_range(0, 9) != 0) ? MID_W'($urandom_range(0, 7))
                                              : MID_W'($urandom_range(0, 63));
            tsk = pick_task();
            if (r < 3) begin
                op = OP_CREATE;
            end else if (r < 5) begin
                op = OP_NONE;
            end else if (r < 52) begin
                op = OP_LOCK;
                if (mid < NM && mtx_held[mid] && $urandom_range(0, 19) == 0)
                    tsk = mtx_owner[mid];
            end else begin
                op = OP_UNLOCK;
                if (mid < NM && mtx_held[mid] && $urandom_range(0, 3) != 0)
                    tsk = mtx_owner[mid];
            end
        end while (hits_blank_link(op, mid, tsk));
    endtask

    task automatic send_req(t_op op, logic [MID_W-1:0] mid, logic [TASK_W-1:0] tsk);
        while (!calm && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, tsk, mid};
        do @(posedge i_clk); while (!s_tready);
        resp_q.push_back(mutex_step(op, mid, tsk));
        n_reqs++;
        @(negedge i_clk);
    endtask

    function automatic t_resp fixed_resp(t_status st, int nm);
        t_resp r;
        r           = '0;
        r.status    = st;
        r.new_mutex = NEW_W'(nm);
        return r;
    endfunction

    task automatic add_row(t_op op, int mid, int tsk, int reps, bit fixed,
                           t_status st = ST_OK, int nm = 0);
        t_row w;
        w.op    = op;
        w.mid   = MID_W'(mid);
        w.tsk   = TASK_W'(tsk);
        w.reps  = reps;
        w.fixed = fixed;
        w.want  = fixed_resp(st, nm);
        rows.push_back(w);
    endtask

    task automatic report(string what, t_resp want, t_resp got);
        n_err++;
        if (n_err <= SHOW_MAX) begin
            $display("mismatch at cycle %0d: %s", cycles, what);
            $display("  expected st=%0d new=%0d blk=%0b wv=%0b wt=%0d",
                     want.status, want.new_mutex, want.blocked,
                     want.woken_valid, want.woken_task);
            $display("  actual   st=%0d new=%0d blk=%0b wv=%0b wt=%0d",
                     got.status, got.new_mutex, got.blocked,
                     got.woken_valid, got.woken_task);
        end
    endtask

    always @(posedge i_clk) begin : result_chk
        t_resp got;
        t_resp want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_resp'(m_tdata);
            n_results++;
            if (resp_q.size() == 0) begin
                report("result item with nothing pending", '0, got);
            end else begin
                want = resp_q.pop_front();
                if (got.status !== want.status || got.new_mutex !== want.new_mutex
                    || got.blocked !== want.blocked
                    || got.woken_valid !== want.woken_valid
                    || got.woken_task !== want.woken_task)
                    report("wrong field", want, got);
                if (want.status <= ST_NOTOWNER) n_status[want.status]++;
                n_blocked += want.blocked;
                n_woken   += want.woken_valid;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= calm || ($urandom_range(0, 99) >= 13);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_op               op;
        logic [MID_W-1:0]  mid;
        logic [TASK_W-1:0] tsk;
        int                waited;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_row(OP_LOCK,    0,  0,  1, 1, ST_INVALID);
        add_row(OP_UNLOCK,  63, 63, 1, 1, ST_INVALID);
        add_row(OP_NONE,    63, 63, 1, 1, ST_OK);
        add_row(OP_CREATE,  0,  0,  1, 1, ST_OK, 0);
        add_row(OP_CREATE,  63, 63, 1, 1, ST_OK, 1);
        add_row(OP_LOCK,    0,  63, 1, 1, ST_OK);
        add_row(OP_LOCK,    0,  63, 1, 1, ST_DEADLOCK);
        add_row(OP_LOCK,    0,  0,  1, 0);
        add_row(OP_LOCK,    0,  42, 1, 0);
        add_row(OP_LOCK,    0,  21, 1, 0);
        add_row(OP_UNLOCK,  0,  0,  1, 1, ST_NOTOWNER);
        add_row(OP_UNLOCK,  0,  63, 1, 0);
        add_row(OP_UNLOCK,  0,  0,  1, 0);
        add_row(OP_UNLOCK,  0,  42, 1, 0);
        add_row(OP_UNLOCK,  0,  21, 1, 1, ST_OK);
        add_row(OP_UNLOCK,  0,  21, 1, 1, ST_NOTOWNER);
        add_row(OP_LOCK,    32, 1,  1, 1, ST_INVALID);
        add_row(OP_LOCK,    2,  1,  1, 1, ST_INVALID);
        add_row(OP_CREATE,  0,  0,  30, 0);
        add_row(OP_CREATE,  0,  0,  1, 1, ST_NOMEM);
        add_row(OP_LOCK,    31, 5,  1, 1, ST_OK);
        add_row(OP_UNLOCK,  31, 5,  1, 1, ST_OK);
        add_row(OP_LOCK,    1,  10, 1, 1, ST_OK);
        add_row(OP_LOCK,    1,  11, 1, 0);
        add_row(OP_LOCK,    2,  12, 1, 1, ST_OK);
        add_row(OP_LOCK,    2,  11, 1, 0);

        foreach (rows[i]) begin
            for (int j = 0; j < rows[i].reps; j++) begin
                send_req(rows[i].op, rows[i].mid, rows[i].tsk);
                if (rows[i].fixed) resp_q[$] = rows[i].want;
            end
        end

        for (int k = 0; k < RAND_REQS; k++) begin
            calm <= (k >= 700 && k < 1000);
            if (k == 300) hold_go <= 1'b1;
            pick_req(op, mid, tsk);
            send_req(op, mid, tsk);
        end
        s_tvalid <= 1'b0;

        while (resp_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d requests, %0d results: %0d ok, %0d no-free, %0d invalid,",
                 n_reqs, n_results, n_status[ST_OK], n_status[ST_NOMEM],
                 n_status[ST_INVALID]);
        $display("%0d deadlock, %0d not-owner, %0d queued waiters, %0d hand-overs",
                 n_status[ST_DEADLOCK], n_status[ST_NOTOWNER], n_blocked, n_woken);
        if (n_err == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", n_err);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
src/fmlm_pkg.sv
src/fmlm_ram.sv
src/fmlm_front.sv
src/fmlm_queue.sv
src/fmlm_back.sv
src/fifo_mutex_lock_manager.sv
sim/tb_top.sv
